[design/rtp_pkg.sv]
// Package for the radix integer text parser.
// Holds the item types, character codes, parse phases and character helpers.
// No dependencies; every other design file imports it.
package rtp_pkg;

    localparam int CH_W      = 8;
    localparam int RADIX_W   = 6;
    localparam int VALUE_W   = 64;
    localparam int INDEX_W   = 16;
    localparam int PROD_W    = VALUE_W + RADIX_W;
    localparam int POSITION_BITS_DEF = 16;

    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd63;

    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic               start_req;
        logic [CH_W-1:0]    ch;
        logic [RADIX_W-1:0] radix;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] end_index;
        logic               got_digits;
    } out_item_t;

    // Handshake between the parse core and the register stages around it.
    typedef struct packed {
        logic item_vld;
        logic out_free;
    } core_ctl_t;

    function automatic logic [RADIX_W-1:0] char_digit(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] d;
        d = CH_W'(DIGIT_NONE);
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA + LETTER_OFS;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA + LETTER_OFS;
        end
        return d[RADIX_W-1:0];
    endfunction

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

[design/rtp_if.sv]
// Channel interfaces of the radix integer text parser: characters in, results out.
// Depends on rtp_pkg for field widths.
interface rtp_in_if import rtp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               start_req;
    logic [CH_W-1:0]    ch;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, start_req, ch, radix, input ready);
    modport sink   (input valid, start_req, ch, radix, output ready);
endinterface

interface rtp_out_if import rtp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] end_index;
    logic               got_digits;

    modport source (output valid, value, end_index, got_digits, input ready);
    modport sink   (input valid, value, end_index, got_digits, output ready);
endinterface

[design/rtp_in_reg.sv]
// Input register of the parser: captures one character item per cycle while it has room.
// Depends on rtp_pkg and rtp_in_if.
module rtp_in_reg
    import rtp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rtp_in_if.sink       chars,
    input  logic         take,
    output logic         item_vld,
    output in_item_t     item
);

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;

    assign chars.ready = !vld_reg || take;
    assign item_vld    = vld_reg;
    assign item        = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (chars.valid && chars.ready) begin
            vld_next = 1'b1;
        end else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready) begin
            item_reg <= '{start_req: chars.start_req, ch: chars.ch, radix: chars.radix};
        end
    end

endmodule

[design/rtp_core.sv]
// Parse core: phase, base, sign, accumulator and position registers, and the
// per-character step that updates them and forms a result. Depends on rtp_pkg.
module rtp_core
    import rtp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  core_ctl_t ctl,
    input  in_item_t  item,
    output logic      take,
    output logic      res_vld,
    output out_item_t res
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    phase_t                   phase_reg, phase_next;
    logic [RADIX_W-1:0]       base_reg, base_next;
    logic                     neg_reg, neg_next;
    logic [VALUE_W-1:0]       acc_reg, acc_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     seen_reg, seen_next;

    phase_t                   ph0;
    logic [RADIX_W-1:0]       base0, base_d, dig;
    logic                     neg0, seen0, seen_d;
    logic [VALUE_W-1:0]       acc0;
    logic [POSITION_BITS-1:0] pos0, pos_inc;
    logic [POSITION_BITS+INDEX_W-1:0] pos_ext;
    logic [PROD_W-1:0]        prod;
    logic                     bad_radix, at_signed, at_zero, at_digits, gen;
    logic [CH_W-1:0]          c;

    assign c         = item.ch;
    assign bad_radix = (item.radix == RADIX_ONE) || (item.radix > RADIX_MAX);
    assign dig       = char_digit(c);
    assign pos_ext   = {{INDEX_W{1'b0}}, pos0};
    assign pos_inc   = (pos0 == POS_MAX) ? pos0 : pos0 + 1'b1;
    assign prod      = acc0 * base_d;

    always_comb
    begin
        // A start request restarts the parse from a clean state.
        if (item.start_req) begin
            ph0   = PH_SPACE;
            base0 = item.radix;
            neg0  = 1'b0;
            acc0  = '0;
            pos0  = '0;
            seen0 = 1'b0;
        end else begin
            ph0   = phase_reg;
            base0 = base_reg;
            neg0  = neg_reg;
            acc0  = acc_reg;
            pos0  = pos_reg;
            seen0 = seen_reg;
        end

        phase_next = ph0;
        base_next  = base0;
        neg_next   = neg0;
        acc_next   = acc0;
        pos_next   = pos0;
        seen_next  = seen0;
        gen        = 1'b0;
        res        = '{value: '0, end_index: '0, got_digits: 1'b0};
        at_signed  = 1'b0;
        at_zero    = 1'b0;
        at_digits  = 1'b0;
        base_d     = base0;
        seen_d     = seen0;

        if (item.start_req && bad_radix) begin
            phase_next = PH_IDLE;
            gen        = 1'b1;
        end else begin
            // The phases may fall through into one another on one character.
            if (ph0 == PH_SPACE) begin
                if (is_blank(c)) begin
                    pos_next = pos_inc;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    neg_next   = (c == CH_MINUS);
                    phase_next = PH_SIGNED;
                    pos_next   = pos_inc;
                end else begin
                    at_signed = 1'b1;
                end
            end
            if (ph0 == PH_SIGNED || at_signed) begin
                if (c == CH_0 && (base0 == RADIX_AUTO || base0 == RADIX_HEX)) begin
                    phase_next = PH_ZERO;
                    pos_next   = pos_inc;
                end else begin
                    base_d    = (base0 == RADIX_AUTO) ? RADIX_DEC : base0;
                    at_digits = 1'b1;
                end
            end
            if (ph0 == PH_ZERO) begin
                at_zero = 1'b1;
                if (c == CH_LX || c == CH_UX) begin
                    base_next  = RADIX_HEX;
                    phase_next = PH_DIGITS;
                    pos_next   = pos_inc;
                end else begin
                    // A lone zero in base sixteen is itself a digit.
                    base_d    = (base0 == RADIX_AUTO) ? RADIX_OCT : base0;
                    seen_d    = seen0 || (base0 != RADIX_AUTO);
                    at_digits = 1'b1;
                end
            end
            if (ph0 == PH_DIGITS || at_digits) begin
                base_next = base_d;
                if (dig < base_d) begin
                    acc_next   = prod[VALUE_W-1:0] + {{(VALUE_W-RADIX_W){1'b0}}, dig};
                    seen_next  = 1'b1;
                    pos_next   = pos_inc;
                    phase_next = PH_DIGITS;
                end else begin
                    seen_next  = seen_d;
                    phase_next = PH_IDLE;
                    gen        = 1'b1;
                    res.value      = neg0 ? ('0 - acc0) : acc0;
                    res.end_index  = seen_d ? pos_ext[INDEX_W-1:0] : '0;
                    res.got_digits = seen_d;
                end
            end
            if (at_zero && ph0 != PH_ZERO) begin
                phase_next = PH_IDLE;
            end
        end
    end

    assign take    = ctl.item_vld && (!gen || ctl.out_free);
    assign res_vld = take && gen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            base_reg  <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

[design/rtp_out_reg.sv]
// Result register of the parser: holds one result item until the sink takes it.
// Depends on rtp_pkg and rtp_out_if.
module rtp_out_reg
    import rtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t res,
    output logic      out_free,
    rtp_out_if.source result
);

    logic      vld_reg;
    logic      vld_next;
    out_item_t res_reg;

    assign out_free          = !vld_reg || result.ready;
    assign result.valid      = vld_reg;
    assign result.value      = res_reg.value;
    assign result.end_index  = res_reg.end_index;
    assign result.got_digits = res_reg.got_digits;

    always_comb
    begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (result.ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

[design/radix_integer_text_parser_unit.sv]
// Channel   Dir   Payload                                   Notes
// chars     in    start_req, ch[7:0], radix[5:0]            one character per item
// result    out   value[63:0], end_index[15:0], got_digits  one item per finished string
//
// One character item is taken per cycle unless a held result stalls it; its result, if any,
// passes from the input register through one step of parse logic into the
// result register. The step is one 64 by 6 bit multiply-add on the accumulator.
// Reset clears the parse state to idle and empties both registers.
// A held result only stalls a character that would itself end a string.
// Depends on rtp_pkg, rtp_if, rtp_in_reg, rtp_core and rtp_out_reg.
module radix_integer_text_parser_unit
    import rtp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rtp_in_if.sink    chars,
    rtp_out_if.source result
);

    logic      item_vld;
    in_item_t  item;
    logic      take;
    logic      res_vld;
    out_item_t res;
    logic      out_free;
    core_ctl_t ctl;

    assign ctl = '{item_vld: item_vld, out_free: out_free};

    rtp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .take     (take),
        .item_vld (item_vld),
        .item     (item)
    );

    rtp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .item    (item),
        .take    (take),
        .res_vld (res_vld),
        .res     (res)
    );

    rtp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_vld),
        .res      (res),
        .out_free (out_free),
        .result   (result)
    );

endmodule
